### hw/rtl/assert_macros.svh
// Assertion macros for the ring queue RTL.
// Bodies compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/vrrq_pkg.sv
// Types and codes for the variable record ring queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package vrrq_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int CNT_W  = 10;
    localparam int FREE_W = 11;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SEQ_ERR   = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              first_byte;
        logic [LEN_W-1:0]  message_length;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  read_offset;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [LEN_W-1:0]  first_length;
        logic [CNT_W-1:0]  message_count;
        logic [FREE_W-1:0] free_bytes;
        logic [CNT_W-1:0]  evicted;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

### hw/rtl/vrrq_ram.sv
// Byte ring storage: one write port, one read port, registered read data.
// Depends on vrrq_pkg.
`timescale 1ns / 1ps
module vrrq_ram import vrrq_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [BYTE_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [BYTE_W-1:0]        o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/vrrq_ctrl.sv
// Sequencer for the ring queue: pointers, counters, eviction walk and header access.
// Depends on vrrq_pkg and assert_macros.svh; drives vrrq_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vrrq_ctrl import vrrq_pkg::*; #(
    parameter int RING_BYTES   = 1024,
    parameter int HEADER_BYTES = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  t_item                         i_item,
    output logic                          o_busy,
    output logic                          o_res_valid,
    output t_result                       o_res,
    input  logic                          i_res_ready,
    output logic                          o_mem_we,
    output logic [$clog2(RING_BYTES)-1:0] o_mem_waddr,
    output logic [BYTE_W-1:0]             o_mem_wdata,
    output logic                          o_mem_re,
    output logic [$clog2(RING_BYTES)-1:0] o_mem_raddr,
    input  logic [BYTE_W-1:0]             i_mem_rdata
);

    localparam int PW  = $clog2(RING_BYTES);
    localparam int PW1 = PW + 1;
    localparam int UW  = $clog2(RING_BYTES + 1);
    localparam int CW  = (UW > 11) ? UW + 1 : 12;
    localparam int HIW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int NHB = (HEADER_BYTES >= 2) ? 2 : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EVICT,
        S_DROP,
        S_HDR_RD,
        S_HDR_CAP,
        S_HDR_WR,
        S_DATA_WR,
        S_RD_CAP,
        S_FINISH
    } t_state;

    t_state             r_state;
    t_item              r_item;
    logic [PW-1:0]      r_oldest;
    logic [PW-1:0]      r_wp;
    logic [PW-1:0]      r_rptr;
    logic [UW-1:0]      r_used;
    logic [UW-1:0]      r_stored;
    logic [UW-1:0]      r_evict;
    logic [LEN_W-1:0]   r_left;
    logic [LEN_W-1:0]   r_open_len;
    logic [LEN_W-1:0]   r_first_len;
    logic               r_open;
    logic               r_is_evict;
    logic [HIW-1:0]     r_hidx;
    logic [STAT_W-1:0]  r_status;
    logic [BYTE_W-1:0]  r_rbyte;

    logic [UW-1:0]      free_now;
    logic [CW-1:0]      rec_len;
    logic [CW-1:0]      rec_old;
    logic [UW-1:0]      drop_len;
    logic [PW-1:0]      oldest_next;
    logic [PW-1:0]      wp_inc;
    logic [PW-1:0]      rptr_inc;
    logic [PW-1:0]      rd_addr;
    logic               too_large;
    logic               need_evict;
    logic               rd_ok;
    logic               cont_ok;
    logic [BYTE_W-1:0]  hdr_byte;

    function automatic logic [PW-1:0] wrap_ptr(input logic [PW1-1:0] sum);
        logic [PW1-1:0] lim;
        lim = PW1'(RING_BYTES);
        if (sum >= lim) begin
            wrap_ptr = PW'(sum - lim);
        end else begin
            wrap_ptr = PW'(sum);
        end
    endfunction

    assign free_now    = UW'(RING_BYTES) - r_used;
    assign rec_len     = CW'(r_item.message_length) + CW'(HEADER_BYTES);
    assign too_large   = (rec_len > CW'(RING_BYTES)) ||
                         ((HEADER_BYTES < 2) && (r_item.message_length[LEN_W-1:8] != '0));
    assign need_evict  = (CW'(free_now) < rec_len) && (r_stored != '0);
    assign rec_old     = CW'(r_first_len) + CW'(HEADER_BYTES);
    assign drop_len    = (rec_old > CW'(r_used)) ? r_used : UW'(rec_old);
    assign oldest_next = wrap_ptr(PW1'(r_oldest) + PW1'(drop_len));
    assign wp_inc      = wrap_ptr(PW1'(r_wp) + PW1'(1));
    assign rptr_inc    = wrap_ptr(PW1'(r_rptr) + PW1'(1));
    assign rd_addr     = wrap_ptr(PW1'(r_oldest) +
                                  PW1'(CW'(r_item.read_offset) + CW'(HEADER_BYTES)));
    assign rd_ok       = (r_item.mode == MODE_READ) && (r_stored != '0) &&
                         (r_item.read_offset < r_first_len);
    assign cont_ok     = (r_item.mode == MODE_APPEND) && !r_item.first_byte && r_open;

    always_comb begin
        if (r_hidx == '0) begin
            hdr_byte = r_item.message_length[7:0];
        end else if (r_hidx == HIW'(1)) begin
            hdr_byte = BYTE_W'(r_item.message_length[LEN_W-1:8]);
        end else begin
            hdr_byte = '0;
        end
    end

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_wdata = r_item.data_byte;
        o_mem_re    = 1'b0;
        o_mem_raddr = rd_addr;
        unique case (r_state)
            S_DECODE: begin
                o_mem_we = cont_ok;
                o_mem_re = rd_ok;
            end
            S_HDR_WR: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = hdr_byte;
            end
            S_DATA_WR: begin
                o_mem_we = 1'b1;
            end
            S_HDR_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_rptr;
            end
            default: begin
            end
        endcase
    end

    assign o_mem_waddr = r_wp;
    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_FINISH);

    assign o_res.read_byte     = r_rbyte;
    assign o_res.first_length  = (r_stored != '0) ? r_first_len : '0;
    assign o_res.message_count = CNT_W'(r_stored);
    assign o_res.free_bytes    = FREE_W'(free_now);
    assign o_res.evicted       = CNT_W'(r_evict);
    assign o_res.status        = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_wp     <= '0;
            r_used   <= '0;
            r_stored <= '0;
            r_left   <= '0;
            r_open   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item   <= i_item;
                        r_evict  <= '0;
                        r_status <= STAT_OK;
                        r_rbyte  <= '0;
                        r_state  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_state <= S_FINISH;
                    unique case (r_item.mode)
                        MODE_APPEND: begin
                            if (r_item.first_byte) begin
                                if (r_open) begin
                                    r_status <= STAT_SEQ_ERR;
                                end else if (too_large) begin
                                    r_status <= STAT_TOO_LARGE;
                                end else begin
                                    r_is_evict <= 1'b1;
                                    r_state    <= S_EVICT;
                                end
                            end else if (!r_open) begin
                                r_status <= STAT_SEQ_ERR;
                            end else begin
                                r_wp   <= wp_inc;
                                r_left <= r_left - LEN_W'(1);
                                if (r_left == LEN_W'(1)) begin
                                    r_open   <= 1'b0;
                                    r_stored <= r_stored + UW'(1);
                                    if (r_stored == '0) begin
                                        r_first_len <= r_open_len;
                                    end
                                end
                            end
                        end
                        MODE_READ: begin
                            if (r_stored == '0) begin
                                r_status <= STAT_EMPTY;
                            end else if (!rd_ok) begin
                                r_status <= STAT_SEQ_ERR;
                            end else begin
                                r_state <= S_RD_CAP;
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_stored == '0) begin
                                r_status <= STAT_EMPTY;
                            end else begin
                                r_is_evict <= 1'b0;
                                r_state    <= S_DROP;
                            end
                        end
                        default: begin
                            r_status <= STAT_SEQ_ERR;
                        end
                    endcase
                end
                S_EVICT: begin
                    if (need_evict) begin
                        r_state <= S_DROP;
                    end else begin
                        r_used  <= r_used + UW'(rec_len);
                        r_hidx  <= '0;
                        r_state <= S_HDR_WR;
                    end
                end
                S_DROP: begin
                    r_oldest <= oldest_next;
                    r_used   <= r_used - drop_len;
                    r_stored <= r_stored - UW'(1);
                    r_rptr   <= oldest_next;
                    r_hidx   <= '0;
                    if (r_is_evict) begin
                        r_evict <= r_evict + UW'(1);
                    end
                    if (r_stored > UW'(1)) begin
                        r_state <= S_HDR_RD;
                    end else if (r_is_evict) begin
                        r_state <= S_EVICT;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_HDR_RD: begin
                    r_state <= S_HDR_CAP;
                end
                S_HDR_CAP: begin
                    if (r_hidx == '0) begin
                        r_first_len <= LEN_W'(i_mem_rdata);
                    end else begin
                        r_first_len[LEN_W-1:8] <= i_mem_rdata[LEN_W-9:0];
                    end
                    if (r_hidx == HIW'(NHB - 1)) begin
                        r_state <= r_is_evict ? S_EVICT : S_FINISH;
                    end else begin
                        r_hidx  <= r_hidx + HIW'(1);
                        r_rptr  <= rptr_inc;
                        r_state <= S_HDR_RD;
                    end
                end
                S_HDR_WR: begin
                    r_wp <= wp_inc;
                    if (r_hidx == HIW'(HEADER_BYTES - 1)) begin
                        if (r_item.message_length == '0) begin
                            r_stored <= r_stored + UW'(1);
                            if (r_stored == '0) begin
                                r_first_len <= '0;
                            end
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_DATA_WR;
                        end
                    end else begin
                        r_hidx <= r_hidx + HIW'(1);
                    end
                end
                S_DATA_WR: begin
                    r_wp   <= wp_inc;
                    r_left <= r_item.message_length - LEN_W'(1);
                    if (r_item.message_length == LEN_W'(1)) begin
                        r_stored <= r_stored + UW'(1);
                        if (r_stored == '0) begin
                            r_first_len <= r_item.message_length;
                        end
                    end else begin
                        r_open     <= 1'b1;
                        r_open_len <= r_item.message_length;
                    end
                    r_state <= S_FINISH;
                end
                S_RD_CAP: begin
                    r_rbyte <= i_mem_rdata;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_no_rw_overlap, i_clk, i_rst_n, !(o_mem_we && o_mem_re), "read and write in one cycle")
    `ASSERT_ALWAYS(a_used_in_range, i_clk, i_rst_n, r_used <= UW'(RING_BYTES), "ring overfilled")
    `ASSERT_IMPLIES(a_empty_no_used, i_clk, i_rst_n, (r_state == S_IDLE) && (r_stored == '0) && !r_open, r_used == '0, "bytes held with no message")
    `ASSERT_IMPLIES(a_open_has_left, i_clk, i_rst_n, r_open, r_left != '0, "open message with no bytes left")

endmodule

### hw/rtl/variable_record_ring_queue_top.sv
// Variable record ring queue: each item passes a decode state and ends in a finish state
// that hands the result to the output register; o_stall stays high until then. Continuation
// appends and refused items go straight to finish, reads capture the byte first, removes
// drop the oldest message and read the header of the next if a complete message remains,
// and a first append evicts old messages as needed, writes the header, then a data byte.
// Synchronous active-low reset clears pointers and counters; the byte memory is not cleared.
`timescale 1ns / 1ps
module variable_record_ring_queue_top import vrrq_pkg::*; #(
    parameter int RING_BYTES   = 1024,
    parameter int HEADER_BYTES = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_first_byte,
    input  logic [LEN_W-1:0]  i_message_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_read_offset,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic [LEN_W-1:0]  o_first_length,
    output logic [CNT_W-1:0]  o_message_count,
    output logic [FREE_W-1:0] o_free_bytes,
    output logic [CNT_W-1:0]  o_evicted,
    output logic [STAT_W-1:0] o_status
);

    localparam int PW = $clog2(RING_BYTES);

    t_item             item;
    t_result           res;
    t_result           r_res;
    logic              r_ovalid;
    logic              res_valid;
    logic              res_ready;
    logic              busy;
    logic              mem_we;
    logic              mem_re;
    logic [PW-1:0]     mem_waddr;
    logic [PW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;

    assign item = '{mode:           i_mode,
                    first_byte:     i_first_byte,
                    message_length: i_message_length,
                    data_byte:      i_data_byte,
                    read_offset:    i_read_offset};

    assign res_ready = !r_ovalid || !i_stall;

    vrrq_ctrl #(
        .RING_BYTES   (RING_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_valid),
        .i_item       (item),
        .o_busy       (busy),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    vrrq_ram #(
        .DEPTH (RING_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
            r_res    <= res;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_stall         = busy;
    assign o_valid         = r_ovalid;
    assign o_read_byte     = r_res.read_byte;
    assign o_first_length  = r_res.first_length;
    assign o_message_count = r_res.message_count;
    assign o_free_bytes    = r_res.free_bytes;
    assign o_evicted       = r_res.evicted;
    assign o_status        = r_res.status;

endmodule
